### design/efc_pkg.sv
package efc_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_STOP   = 2'd1;
	localparam logic [1:0] REG_ESCAPE = 2'd2;

	localparam logic [7:0]  START_RESET  = 8'h02;
	localparam logic [7:0]  STOP_RESET   = 8'h03;
	localparam logic [7:0]  ESCAPE_RESET = 8'h10;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;

	// One classified item, as handed from the front to the back
	typedef struct packed {
		logic [7:0] data;
		logic       data_esc;
		logic       last;
		logic [7:0] crc_hi;
		logic       crc_hi_esc;
		logic [7:0] crc_lo;
		logic       crc_lo_esc;
		logic [7:0] esc_byte;
	} efc_entry_t;

	// Output slots of one item, in emission order
	typedef enum logic [2:0] {
		PH_ESC_DATA = 3'd0,
		PH_DATA     = 3'd1,
		PH_ESC_HI   = 3'd2,
		PH_HI       = 3'd3,
		PH_ESC_LO   = 3'd4,
		PH_LO       = 3'd5
	} efc_phase_t;

endpackage

### design/efc_front.sv
module efc_front import efc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	input  logic        in_take,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output efc_entry_t  entry
);

	logic [7:0]  start_q;
	logic [7:0]  stop_q;
	logic [7:0]  escape_q;
	logic [15:0] crc_q;
	logic [15:0] crc_new;
	logic [1:0]  reg_idx;

	// Fold one byte into the CRC, LSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic special(input logic [7:0] b, input logic [7:0] s,
			input logic [7:0] p, input logic [7:0] e);
		return (b == s) || (b == p) || (b == e);
	endfunction

	assign reg_idx = paddr[3:2];

	// Write configuration registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RESET;
			stop_q   <= STOP_RESET;
			escape_q <= ESCAPE_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_START:  start_q  <= pwdata[7:0];
				REG_STOP:   stop_q   <= pwdata[7:0];
				REG_ESCAPE: escape_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_START:  prdata = {24'h0, start_q};
			REG_STOP:   prdata = {24'h0, stop_q};
			REG_ESCAPE: prdata = {24'h0, escape_q};
			default:    prdata = 32'h0;
		endcase
	end

	assign crc_new = crc_fold(crc_q, data_byte);

	// Advance the CRC; restart after the flagged byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (in_take) begin
			crc_q <= last_byte ? CRC_INIT : crc_new;
		end
	end

	// Classify the item for the back
	always_comb begin
		entry.data       = data_byte;
		entry.data_esc   = special(data_byte, start_q, stop_q, escape_q);
		entry.last       = last_byte;
		entry.crc_hi     = crc_new[15:8];
		entry.crc_hi_esc = special(crc_new[15:8], start_q, stop_q, escape_q);
		entry.crc_lo     = crc_new[7:0];
		entry.crc_lo_esc = special(crc_new[7:0], start_q, stop_q, escape_q);
		entry.esc_byte   = escape_q;
	end

endmodule

### design/efc_queue.sv
module efc_queue import efc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  efc_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output efc_entry_t rd_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	efc_entry_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	// Store items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Track pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### design/efc_back.sv
module efc_back import efc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       has_entry,
	input  efc_entry_t entry,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       frame_end
);

	efc_phase_t phase_q;
	efc_phase_t phase_d;
	efc_phase_t slot;
	logic       present;
	logic       load;
	logic       slot_end;
	logic [7:0] slot_byte;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       frame_end_q;

	assign load = has_entry && (!valid_q || out_ready);

	// Pick the slot to emit and what follows it
	always_comb begin
		case (phase_q)
			PH_ESC_DATA: present = entry.data_esc;
			PH_DATA:     present = 1'b1;
			PH_ESC_HI:   present = entry.last && entry.crc_hi_esc;
			PH_HI:       present = entry.last;
			PH_ESC_LO:   present = entry.last && entry.crc_lo_esc;
			PH_LO:       present = entry.last;
			default:     present = 1'b1;
		endcase
		slot = present ? phase_q : efc_phase_t'(phase_q + 3'd1);
		case (slot)
			PH_ESC_DATA: slot_byte = entry.esc_byte;
			PH_DATA:     slot_byte = entry.data;
			PH_ESC_HI:   slot_byte = entry.esc_byte;
			PH_HI:       slot_byte = entry.crc_hi;
			PH_ESC_LO:   slot_byte = entry.esc_byte;
			PH_LO:       slot_byte = entry.crc_lo;
			default:     slot_byte = entry.data;
		endcase
		slot_end = ((slot == PH_DATA) && !entry.last) || (slot == PH_LO);
		pop      = load && slot_end;
		if (!load) begin
			phase_d = phase_q;
		end else if (slot_end) begin
			phase_d = PH_ESC_DATA;
		end else begin
			phase_d = efc_phase_t'(slot + 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ESC_DATA;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q      <= slot_byte;
			run_end_q   <= slot_end;
			frame_end_q <= (slot == PH_LO);
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

endmodule

### design/escaped_framer_crc16_modbus_unit.sv
// Channel   Handshake            Payload
// input     in_valid/in_ready    data_byte, last_byte
// output    out_valid/out_ready  out_byte, run_end, frame_end
// config    APB psel/penable     paddr, pwdata, prdata, pready
//
// The front folds each item into the CRC in its accept cycle and queues it.
// The back emits one byte per cycle unless stalled: 1 or 2 per ordinary
// item, 3 to 6 per flagged one; its single output byte sets the rate.
// in_ready drops only when the queue is full; the output register holds a
// byte until taken. Reset clears the CRC to FFFF and empties the queue.
module escaped_framer_crc16_modbus_unit import efc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        frame_end
);

	efc_entry_t wr_entry;
	efc_entry_t rd_entry;
	logic       in_take;
	logic       q_full;
	logic       q_has;
	logic       q_pop;

	assign pready   = 1'b1;
	assign in_ready = !q_full;
	assign in_take  = in_valid && !q_full;

	efc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.in_take   (in_take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.entry     (wr_entry)
	);

	efc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_take),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_has),
		.rd_entry  (rd_entry)
	);

	efc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.has_entry (q_has),
		.entry     (rd_entry),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

endmodule
